// ===== src/vat_pkg.sv =====
// shared types and constants of the vertex affine transform block
package vat_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned N_ELEM  = 16;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  // multiply order codes
  localparam logic ORDER_ROW = 1'b0;
  localparam logic ORDER_COL = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

  // one queued word: a load carries its value in lane 0
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index;
    word_t [3:0]      val;
  } entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

// ===== src/vat_front.sv =====
// front end: accepts words, classifies them and queues them for the back end
module vat_front import vat_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [IDX_W-1:0]    element_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic signed [DATA_W-1:0] in_x_i,
  input  logic signed [DATA_W-1:0] in_y_i,
  input  logic signed [DATA_W-1:0] in_z_i,
  input  logic signed [DATA_W-1:0] in_w_i,
  output queue_head_t         head_o,
  input  logic                pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  entry_t             entry_d;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push;

  // classify the incoming word and pack only the fields that matter
  always_comb begin
    entry_d.kind  = kind_i;
    entry_d.index = '0;
    entry_d.val   = '0;
    unique case (kind_i)
      KIND_LOAD: begin
        entry_d.index  = element_index_i;
        entry_d.val[0] = element_value_i;
      end
      KIND_XFORM: begin
        entry_d.val[0] = in_x_i;
        entry_d.val[1] = in_y_i;
        entry_d.val[2] = in_z_i;
        entry_d.val[3] = in_w_i;
      end
      default: begin
        entry_d.kind = KIND_LOAD;
      end
    endcase
  end

  // queue status
  assign in_stall_o    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign push          = in_valid_i && !in_stall_o;
  assign head_o.valid  = (count_q != '0);
  assign head_o.entry  = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // queue never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // back end only pops a filled queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

  // a push without a pop grows the queue by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("queue count did not grow on push");

endmodule

// ===== src/vat_back.sv =====
// back end: matrix store, multiply stage, adder stages and result register
module vat_back import vat_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  queue_head_t              head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o,
  output logic                     saturated_o
);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(64'd1 << FRAC_BITS);

  logic                     order_q;
  word_t                    mat_q [N_ELEM];
  logic                     advance, load_en, xform_en;
  logic                     s1_valid_q, s2_valid_q, out_valid_q;
  logic signed [PROD_W-1:0] prod_d [3][4];
  logic signed [PROD_W-1:0] prod_q [3][4];
  logic signed [PAIR_W-1:0] pair_d [3][2];
  logic signed [PAIR_W-1:0] pair_q [3][2];
  logic signed [SUM_W-1:0]  sum_d  [3];
  logic signed [SUM_W-1:0]  shr_d  [3];
  logic [SUM_W-DATA_W:0]    top_d  [3];
  logic [2:0]               ovf_d;
  word_t                    res_d  [3];
  word_t                    res_q  [3];
  logic                     sat_q;

  // pipeline moves unless the result register is held
  assign advance  = !(out_valid_q && out_stall_i);
  assign pop_o    = head_i.valid && advance;
  assign load_en  = pop_o && (head_i.entry.kind == KIND_LOAD);
  assign xform_en = pop_o && (head_i.entry.kind == KIND_XFORM);

  // order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_ROW;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // matrix store, identity after reset, written at the index of each load word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ELEM; i++) begin
        mat_q[i] <= ((i % 5) == 0) ? ONE : '0;
      end
    end else if (load_en) begin
      mat_q[head_i.entry.index] <= head_i.entry.val[0];
    end
  end

  // twelve products, coefficient picked by the multiply order
  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      word_t coef;
      assign coef = (order_q == ORDER_COL) ? mat_q[4*k + j] : mat_q[4*j + k];
      assign prod_d[k][j] = $signed(coef) * $signed(head_i.entry.val[j]);
    end
  end

  // pairwise sums
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pair_d[k][0] = PAIR_W'(prod_q[k][0]) + PAIR_W'(prod_q[k][1]);
      pair_d[k][1] = PAIR_W'(prod_q[k][2]) + PAIR_W'(prod_q[k][3]);
    end
  end

  // final sum, scale back and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = SUM_W'(pair_q[k][0]) + SUM_W'(pair_q[k][1]);
      shr_d[k] = sum_d[k] >>> FRAC_BITS;
      top_d[k] = shr_d[k][SUM_W-1:DATA_W-1];
      ovf_d[k] = !((&top_d[k]) || !(|top_d[k]));
      if (ovf_d[k]) begin
        res_d[k] = shr_d[k][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res_d[k] = shr_d[k][DATA_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[k][j] <= prod_d[k][j];
        end
        pair_q[k][0] <= pair_d[k][0];
        pair_q[k][1] <= pair_d[k][1];
        res_q[k]     <= res_d[k];
      end
      sat_q <= |ovf_d;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= xform_en;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign saturated_o = sat_q;

  // a load word never enters the arithmetic stages
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> !s1_valid_q)
    else $error("load word launched a result");

  // a finished sum reaches the result register when the pipe moves
  a_s2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && advance) |=> out_valid_q)
    else $error("result lost between adder and output");

  // a held pipe keeps the multiply stage word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("multiply stage word dropped during stall");

endmodule

// ===== src/vertex_affine_transform_core.sv =====
// top level of the vertex affine transform block
//
// Input channel (in_valid_i / in_stall_o) takes one word per cycle: a load
// word (kind 0) writes one row-major element of the 4x4 Q16.16 matrix, a
// transform word (kind 1) carries x, y, z, w and yields one result word.
// Output channel (out_valid_o / out_stall_i) gives x', y', z' and a
// saturated flag, one word per transform, in input order.
// cfg_we_i writes the multiply order: 0 vector times matrix, 1 matrix
// times vector; write it only while no word is in flight.
// Throughput: one word per cycle unless out_stall_i holds the pipe,
// set by the single multiply stage of twelve 32x32 multipliers; loads and
// transforms mix freely; a load takes effect for the very next transform.
// A popped transform passes the multiply stage, the pair add and the final
// add with saturation into the result register.
// Reset loads the identity matrix, clears the order and empties the queue.
// When the receiver stalls the result register and pipeline hold; the
// front queue keeps accepting until its QUEUE_DEPTH entries are full.
module vertex_affine_transform_core import vat_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         element_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic signed [DATA_W-1:0] in_x_i,
  input  logic signed [DATA_W-1:0] in_y_i,
  input  logic signed [DATA_W-1:0] in_z_i,
  input  logic signed [DATA_W-1:0] in_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o,
  output logic                     saturated_o
);

  queue_head_t head;
  logic        pop;

  // accept and queue
  vat_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .in_x_i          (in_x_i),
    .in_y_i          (in_y_i),
    .in_z_i          (in_z_i),
    .in_w_i          (in_w_i),
    .head_o          (head),
    .pop_i           (pop)
  );

  // matrix store and arithmetic
  vat_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

endmodule
